### hdl/gdn_pkg.sv
// Package for the Gregorian date to day number pipeline.
// Holds the item structs and the month tables; no dependencies.
package gdn_pkg;

	localparam logic [13:0] YEAR_MIN = 14'd1;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int RECIP_100_SHIFT = 19;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0] month;
		logic [4:0] day;
	} date_in_t;

	typedef struct packed {
		logic valid_res;
		logic leap;
		logic [8:0] day_of_year;
		logic [21:0] day_number;
		logic [2:0] weekday;
	} date_out_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		begin
			unique case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				4'd2: len = leap ? 5'd29 : 5'd28;
				default: len = 5'd0;
			endcase
			return len;
		end
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] cum;
		begin
			unique case (m)
				4'd2: cum = 9'd31;
				4'd3: cum = 9'd59;
				4'd4: cum = 9'd90;
				4'd5: cum = 9'd120;
				4'd6: cum = 9'd151;
				4'd7: cum = 9'd181;
				4'd8: cum = 9'd212;
				4'd9: cum = 9'd243;
				4'd10: cum = 9'd273;
				4'd11: cum = 9'd304;
				4'd12: cum = 9'd334;
				default: cum = 9'd0;
			endcase
			return cum;
		end
	endfunction

endpackage

### hdl/gdn_mod7.sv
// Remainder of a 22-bit day count by seven, used for the weekday.
// Sums octal digits (8 is 1 mod 7) and folds; depends on nothing.
module gdn_mod7 (
	input logic [21:0] value,
	output logic [2:0] rem
);

	logic [23:0] padded;
	logic [5:0] digit_sum;
	logic [3:0] fold;

	always_comb begin
		padded = {2'b00, value};
		digit_sum = 6'd0;
		for (int i = 0; i < 8; i++) begin
			digit_sum = digit_sum + {3'b000, padded[3*i +: 3]};
		end
		fold = {1'b0, digit_sum[5:3]} + {1'b0, digit_sum[2:0]};
		if (fold >= 4'd14) begin
			rem = 3'(fold - 4'd14);
		end else if (fold >= 4'd7) begin
			rem = 3'(fold - 4'd7);
		end else begin
			rem = fold[2:0];
		end
	end

endmodule

### hdl/gregorian_date_to_day_number.sv
// Gregorian date to day number, leap flag, day of year and weekday.
// Top level pipeline; uses gdn_pkg and gdn_mod7.
//
// Takes one proleptic Gregorian date per clock while not stalled and returns the
// validity flag, leap flag, day of year, day count from 0001-01-01 (that day is 1)
// and weekday (0 = Sunday). Invalid dates (year outside 1..9999, month outside
// 1..12, day outside the month) give valid_res = 0 with every other field zero.
// Throughput is one item per cycle unless stalled; there is one register stage per step
// (year split, divide by 100, leap and 365 product, day of year and base count,
// sum, weekday). A stall on out_ready holds the whole pipeline and drops in_ready.
module gregorian_date_to_day_number
	import gdn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input date_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output date_out_t out_data
);

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [13:0] prev_s1;
	logic [3:0] month_s1;
	logic [4:0] day_s1;
	logic year_ok_s1;

	logic [13:0] prev_s2;
	logic [3:0] month_s2;
	logic [4:0] day_s2;
	logic year_ok_s2;
	logic [7:0] q100_s2;
	logic [26:0] prod100;

	logic [14:0] hund_mul;
	logic [13:0] rem_wide;
	logic [6:0] rem100;
	logic leap_c;
	logic leap_s3;
	logic [7:0] q100_s3;
	logic [22:0] prod365_s3;
	logic [11:0] q4_s3;
	logic [3:0] month_s3;
	logic [4:0] day_s3;
	logic year_ok_s3;

	logic [4:0] mlen;
	logic date_ok;
	logic valid_s4;
	logic leap_s4;
	logic [8:0] doy_s4;
	logic [22:0] base_s4;

	logic valid_s5;
	logic leap_s5;
	logic [8:0] doy_s5;
	logic [21:0] dn_s5;
	logic [22:0] dn_sum;

	logic [2:0] wday;
	date_out_t res_s6;

	assign adv = !v_s6 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: prior-year count and range checks.
	always_ff @(posedge clk) begin
		if (adv) begin
			prev_s1 <= in_data.year - 14'd1;
			month_s1 <= in_data.month;
			day_s1 <= in_data.day;
			year_ok_s1 <= (in_data.year >= YEAR_MIN) && (in_data.year <= YEAR_MAX);
		end
	end

	// Stage 2: quotient by 100 through the reciprocal, exact for 14-bit values.
	assign prod100 = 27'(prev_s1) * 27'(RECIP_100);

	always_ff @(posedge clk) begin
		if (adv) begin
			prev_s2 <= prev_s1;
			month_s2 <= month_s1;
			day_s2 <= day_s1;
			year_ok_s2 <= year_ok_s1;
			q100_s2 <= prod100[RECIP_100_SHIFT +: 8];
		end
	end

	// Stage 3: remainder by 100, leap flag, 365 product.
	// y mod 4 = 0 iff prev mod 4 = 3; likewise for 100 and 400.
	always_comb begin
		hund_mul = 15'(q100_s2) * 15'd100;
		rem_wide = prev_s2 - hund_mul[13:0];
		rem100 = rem_wide[6:0];
		leap_c = ((prev_s2[1:0] == 2'b11) && (rem100 != 7'd99))
			|| ((rem100 == 7'd99) && (q100_s2[1:0] == 2'b11));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			leap_s3 <= leap_c;
			q100_s3 <= q100_s2;
			prod365_s3 <= 23'(prev_s2) * 23'd365;
			q4_s3 <= prev_s2[13:2];
			month_s3 <= month_s2;
			day_s3 <= day_s2;
			year_ok_s3 <= year_ok_s2;
		end
	end

	// Stage 4: date check, day of year, count up to the end of the prior year.
	always_comb begin
		mlen = month_len(month_s3, leap_s3);
		date_ok = year_ok_s3 && (month_s3 >= 4'd1) && (month_s3 <= MONTH_DEC)
			&& (day_s3 != 5'd0) && (day_s3 <= mlen);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			valid_s4 <= date_ok;
			leap_s4 <= leap_s3;
			doy_s4 <= days_before(month_s3) + 9'(day_s3)
				+ 9'(leap_s3 && (month_s3 > MONTH_FEB));
			base_s4 <= prod365_s3 + 23'(q4_s3) - 23'(q100_s3) + 23'(q100_s3[7:2]);
		end
	end

	// Stage 5: day number; day number, day of year and leap flag are zeroed for an invalid date.
	assign dn_sum = base_s4 + 23'(doy_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			valid_s5 <= valid_s4;
			leap_s5 <= valid_s4 && leap_s4;
			doy_s5 <= valid_s4 ? doy_s4 : 9'd0;
			dn_s5 <= valid_s4 ? dn_sum[21:0] : 22'd0;
		end
	end

	// Stage 6: weekday and output register.
	gdn_mod7 u_mod7 (
		.value(dn_s5),
		.rem(wday)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6.valid_res <= valid_s5;
			res_s6.leap <= leap_s5;
			res_s6.day_of_year <= doy_s5;
			res_s6.day_number <= dn_s5;
			res_s6.weekday <= wday;
		end
	end

	assign out_valid = v_s6;
	assign out_data = res_s6;

`ifndef SYNTH
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.valid_res) |-> (!out_data.leap
			&& (out_data.day_of_year == 9'd0) && (out_data.day_number == 22'd0)
			&& (out_data.weekday == 3'd0)))
		else $error("invalid date item carries nonzero fields");

	a_valid_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.valid_res) |-> ((out_data.day_of_year != 9'd0)
			&& (out_data.day_of_year <= 9'd366) && (out_data.weekday <= 3'd6)
			&& (out_data.day_number != 22'd0)))
		else $error("valid date item out of range");

	a_nonleap_doy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.valid_res && !out_data.leap)
			|-> (out_data.day_of_year <= 9'd365))
		else $error("day 366 in a common year");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !adv) |=> v_s5)
		else $error("pipeline lost an item during a stall");
`endif

endmodule

### verif/gdn_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Gregorian date to day number block: watches both item channels,
// predicts each result from the accepted date and compares field by field. Uses gdn_pkg.
module gdn_checker
	import gdn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input date_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input date_out_t out_data,
	output int fail_count,
	output int pending
);

	localparam int unsigned MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	date_out_t awaited_counts [$];
	date_out_t want;

	function automatic date_out_t count_days(input date_in_t d);
		date_out_t r;
		int unsigned y, m, dd, mlen, doy, py, dn;
		bit lp;
		r = '0;
		y = d.year;
		m = d.month;
		dd = d.day;
		if (y < YEAR_MIN || y > YEAR_MAX || m < 1 || m > MONTH_DEC) begin
			return r;
		end
		lp = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		mlen = MONTH_DAYS[m];
		if (m == MONTH_FEB && lp) begin
			mlen = 29;
		end
		if (dd < 1 || dd > mlen) begin
			return r;
		end
		doy = dd;
		for (int unsigned k = 1; k < m; k++) begin
			doy += MONTH_DAYS[k];
		end
		if (lp && m > MONTH_FEB) begin
			doy += 1;
		end
		py = y - 1;
		dn = 365 * py + py / 4 - py / 100 + py / 400 + doy;
		r.valid_res = 1'b1;
		r.leap = lp;
		r.day_of_year = 9'(doy);
		r.day_number = 22'(dn);
		r.weekday = 3'(dn % 7);
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_counts.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_counts.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: unexpected result item v=%0d leap=%0d doy=%0d dn=%0d wd=%0d",
							$time, out_data.valid_res, out_data.leap, out_data.day_of_year,
							out_data.day_number, out_data.weekday);
					end
					fail_count++;
				end else begin
					want = awaited_counts.pop_front();
					if (out_data.valid_res !== want.valid_res || out_data.leap !== want.leap ||
							out_data.day_of_year !== want.day_of_year ||
							out_data.day_number !== want.day_number ||
							out_data.weekday !== want.weekday) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch expected v=%0d leap=%0d doy=%0d dn=%0d wd=%0d",
								$time, want.valid_res, want.leap, want.day_of_year,
								want.day_number, want.weekday);
							$display("%0t:            got v=%0d leap=%0d doy=%0d dn=%0d wd=%0d",
								$time, out_data.valid_res, out_data.leap, out_data.day_of_year,
								out_data.day_number, out_data.weekday);
						end
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				awaited_counts.push_back(count_days(in_data));
			end
		end
		pending = awaited_counts.size();
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Top of the date to day number testbench: clock, reset, date stimulus and verdict.
// Depends on gdn_pkg, gregorian_date_to_day_number and gdn_checker.
module testbench;
	import gdn_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	date_in_t in_data;
	logic out_valid;
	logic out_ready;
	date_out_t out_data;
	int fail_count;
	int pending;
	int send_calm;
	int recv_calm;
	date_in_t date;
	int unsigned pick;

	gregorian_date_to_day_number u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	gdn_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic date_in_t ymd(input int unsigned y, input int unsigned m,
			input int unsigned d);
		date_in_t r;
		r.year = 14'(y);
		r.month = 4'(m);
		r.day = 5'(d);
		return r;
	endfunction

	task automatic send_date(input date_in_t d);
		int gap;
		gap = $urandom_range(0, 12);
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			send_calm = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold off until every result is back
	task automatic drain_dates();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	initial begin
		int stall;
		out_ready <= 1'b0;
		recv_calm = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 12);
			if (recv_calm > 0) begin
				recv_calm--;
				stall = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				recv_calm = $urandom_range(10, 40);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		send_calm = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_date(ymd(1, 1, 1));
		send_date(ymd(9999, 12, 31));
		send_date(ymd(0, 1, 1));
		send_date(ymd(10000, 1, 1));
		send_date(ymd(16383, 15, 31));
		send_date(ymd(2024, 0, 10));
		send_date(ymd(2024, 13, 10));
		send_date(ymd(2024, 15, 10));
		send_date(ymd(2024, 5, 0));
		send_date(ymd(2024, 4, 31));
		send_date(ymd(2024, 1, 31));
		send_date(ymd(2000, 2, 29));
		send_date(ymd(1900, 2, 29));
		send_date(ymd(2024, 2, 29));
		send_date(ymd(2023, 2, 29));
		send_date(ymd(2100, 2, 28));
		send_date(ymd(1600, 2, 29));
		send_date(ymd(2000, 3, 1));
		send_date(ymd(1999, 3, 1));
		send_date(ymd(2000, 12, 31));
		send_date(ymd(2001, 1, 1));
		send_date(ymd(2023, 12, 31));
		send_date(ymd(9999, 2, 30));
		send_date(ymd(1, 12, 31));
		drain_dates();

		for (int i = 0; i < 700; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				date.year = 14'($urandom_range(1, 9999));
				date.month = 4'($urandom_range(1, 12));
				date.day = 5'($urandom_range(1, 28));
			end else if (pick < 85) begin
				// month ends around century and leap years
				date.year = 14'($urandom_range(1, 99) * 100 + $urandom_range(0, 8) - 4);
				date.month = 4'($urandom_range(1, 12));
				date.day = 5'($urandom_range(28, 31));
			end else begin
				date.year = 14'($urandom_range(0, 16383));
				date.month = 4'($urandom_range(0, 15));
				date.day = 5'($urandom_range(0, 31));
			end
			send_date(date);
			if (i == 350) begin
				drain_dates();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
